// ===== hdl/bmid_pkg.sv =====
package bmid_pkg;

    // Payload widths
    localparam int KIND_W   = 2;
    localparam int ID_W     = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;

    // Limit register value after reset
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 9'd256;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC_ID = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE     = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NONE_FREE = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_TAKEN     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_ALLOC = 3'd4;

    // Sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD
    } state_t;

endpackage

// ===== hdl/bmid_ifs.sv =====
interface bmid_req_if;
    import bmid_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   req_id;

    modport source (output valid, output kind, output req_id, input ready);
    modport sink (input valid, input kind, input req_id, output ready);
endinterface

interface bmid_rsp_if;
    import bmid_pkg::*;

    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     result_id;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;

    modport source (output valid, output result_id, output status, output free_count,
                    input ready);
    modport sink (input valid, input result_id, input status, input free_count,
                  output ready);
endinterface

// ===== hdl/bmid_ram.sv =====
module bmid_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bmid_ffz.sv =====
module bmid_ffz #(
    parameter int N = 8,
    localparam int IW = (N > 1) ? $clog2(N) : 1
) (
    input  logic [N-1:0]  vec,
    output logic          any,
    output logic [IW-1:0] idx
);

    localparam int P = 1 << IW;

    logic [P-1:0]  v_lvl [IW+1];
    logic [IW-1:0] i_lvl [IW+1][P];

    // Load the leaves, pad unused ones as clear
    for (genvar j = 0; j < P; j++)
    begin : g_leaf
        if (j < N)
        begin : g_real
            assign v_lvl[0][j] = vec[j];
        end
        else
        begin : g_pad
            assign v_lvl[0][j] = 1'b0;
        end
        assign i_lvl[0][j] = '0;
    end

    // Combine pairs, lower half wins
    for (genvar k = 0; k < IW; k++)
    begin : g_lvl
        for (genvar j = 0; j < (P >> (k + 1)); j++)
        begin : g_node
            assign v_lvl[k+1][j] = v_lvl[k][2*j] | v_lvl[k][2*j+1];
            assign i_lvl[k+1][j] = v_lvl[k][2*j] ? i_lvl[k][2*j]
                                 : (i_lvl[k][2*j+1] | IW'(1 << k));
        end
    end

    assign any = v_lvl[IW][0];
    assign idx = i_lvl[IW][0];

endmodule

// ===== hdl/bitmap_id_allocator_top.sv =====
// Bitmap identifier allocator, lowest free first.
// Channels: req (sink) carries kind and req_id; rsp (source) carries result_id,
// status and free_count. An item moves when valid and ready are both high.
// cfg_we/cfg_data write the identifier limit; write it only while idle.
// Every request gives exactly one result item, in request order.
// An accepted item passes the modify step, then the output register, to rsp.
// No request is taken in the modify step. The bitmap word is read from the
// RAM in the accept cycle and written back in the following cycle, so the
// single read-modify-write of the word RAM ends before a new request is taken.
// A per-word full bit in flops picks the lowest non-full word for an allocate.
// Reset: used count clears, limit becomes 256, then a clearing pass zeroes the
// word RAM, one word a cycle; req.ready stays low until it ends.
// Stall: the result waits in an output register; a new item is taken only
// when that register is empty or being emptied in the same cycle.
module bitmap_id_allocator_top #(
    parameter int MAX_IDS   = 256,
    parameter int WORD_BITS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bmid_pkg::COUNT_W-1:0] cfg_data,
    bmid_req_if.sink                     req,
    bmid_rsp_if.source                   rsp
);
    import bmid_pkg::*;

    localparam int NWORDS   = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BW       = $clog2(WORD_BITS);
    localparam int CW       = $clog2(NWORDS * WORD_BITS);
    localparam int CMPW     = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int MAX_CLIP = (MAX_IDS > 511) ? 511 : MAX_IDS;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]   id_limit_reg;
    logic [COUNT_W-1:0]   used_reg;
    logic [COUNT_W-1:0]   used_next;
    logic [WA-1:0]        clr_cnt_reg;
    logic [NWORDS-1:0]    full_reg;

    logic [KIND_W-1:0]    kind_reg;
    logic [ID_W-1:0]      rid_reg;
    logic [BW-1:0]        req_bit_reg;
    logic [WA-1:0]        word_reg;
    logic [CMPW-1:0]      base_reg;
    logic                 nonfull_reg;
    logic                 range_err_reg;

    logic                 out_valid_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [COUNT_W-1:0]   out_free_reg;

    logic                 req_ready;
    logic                 clr_active;
    logic                 accept;
    logic [COUNT_W-1:0]   lim;
    logic                 range_err;
    logic [WA-1:0]        req_word;
    logic [BW-1:0]        req_bit;

    logic                 sum_any;
    logic [WA-1:0]        sum_idx;
    logic [WORD_BITS-1:0] rd_data;
    logic                 bit_any;
    logic [BW-1:0]        bit_idx;

    logic                 ram_we;
    logic [WA-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WA-1:0]        ram_raddr;

    logic                 mod_we;
    logic [WORD_BITS-1:0] mod_wdata;
    logic [ID_W-1:0]      mod_id;
    logic [STATUS_W-1:0]  mod_status;
    logic [COUNT_W-1:0]   mod_free;
    logic [CMPW-1:0]      cand_id;
    logic [WORD_BITS-1:0] one_word;

    assign one_word = {{(WORD_BITS-1){1'b0}}, 1'b1};

    // Effective limit
    assign lim = (int'(id_limit_reg) < MAX_IDS) ? id_limit_reg : COUNT_W'(MAX_CLIP);

    assign accept = req.valid && req_ready;

    // Split the requested identifier into word and bit
    always_comb
    begin
        req_word = '0;
        req_bit  = '0;
        for (int k = 0; k < NWORDS; k++)
        begin
            if (k * WORD_BITS <= 255)
            begin
                if ((int'(req.req_id) >= k * WORD_BITS) &&
                    (int'(req.req_id) < (k + 1) * WORD_BITS))
                begin
                    req_word = req_word | WA'(k);
                    req_bit  = req_bit | BW'(int'(req.req_id) - k * WORD_BITS);
                end
            end
        end
    end

    // Flag out-of-range identifiers and unknown kinds
    always_comb
    begin
        if (req.kind == KIND_ALLOC_ID || req.kind == KIND_FREE)
        begin
            range_err = ({1'b0, req.req_id} >= lim);
        end
        else
        begin
            range_err = (req.kind != KIND_ALLOC);
        end
    end

    // Find the lowest word that still has a free bit
    bmid_ffz #(.N(NWORDS)) u_sum_ffz (
        .vec (~full_reg),
        .any (sum_any),
        .idx (sum_idx)
    );

    // Find the lowest free bit in the word just read
    bmid_ffz #(.N(WORD_BITS)) u_bit_ffz (
        .vec (~rd_data),
        .any (bit_any),
        .idx (bit_idx)
    );

    // Word RAM port selection; write back only in the modify step
    assign ram_we    = clr_active || ((state_reg == S_MOD) && mod_we);
    assign ram_waddr = clr_active ? clr_cnt_reg : word_reg;
    assign ram_wdata = clr_active ? '0 : mod_wdata;
    assign ram_raddr = (req.kind == KIND_ALLOC) ? sum_idx : req_word;

    bmid_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // Modify the word and form the result
    always_comb
    begin
        mod_we     = 1'b0;
        mod_wdata  = rd_data;
        mod_id     = '0;
        mod_status = STAT_OK;
        used_next  = used_reg;
        cand_id    = base_reg + CMPW'(bit_idx);
        priority if (range_err_reg)
        begin
            mod_status = STAT_RANGE;
        end
        else if (kind_reg == KIND_ALLOC)
        begin
            if (!nonfull_reg || !bit_any || (cand_id >= CMPW'(lim)))
            begin
                mod_status = STAT_NONE_FREE;
            end
            else
            begin
                mod_we    = 1'b1;
                mod_wdata = rd_data | (one_word << bit_idx);
                mod_id    = cand_id[ID_W-1:0];
                used_next = used_reg + 9'd1;
            end
        end
        else if (kind_reg == KIND_ALLOC_ID)
        begin
            if (rd_data[req_bit_reg])
            begin
                mod_status = STAT_TAKEN;
            end
            else
            begin
                mod_we    = 1'b1;
                mod_wdata = rd_data | (one_word << req_bit_reg);
                mod_id    = rid_reg;
                used_next = used_reg + 9'd1;
            end
        end
        else
        begin
            if (!rd_data[req_bit_reg])
            begin
                mod_status = STAT_NOT_ALLOC;
            end
            else
            begin
                mod_we    = 1'b1;
                mod_wdata = rd_data & ~(one_word << req_bit_reg);
                mod_id    = rid_reg;
                used_next = used_reg - 9'd1;
            end
        end
        mod_free = (lim > used_next) ? (lim - used_next) : '0;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == WA'(NWORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        req_ready  = 1'b0;
        clr_active = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_active = 1'b1;
            end
            S_IDLE:
            begin
                req_ready = !out_valid_reg || rsp.ready;
            end
            S_MOD:
            begin
                req_ready = 1'b0;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            id_limit_reg  <= LIMIT_RESET;
            used_reg      <= '0;
            full_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_active)
            begin
                clr_cnt_reg <= clr_cnt_reg + WA'(1);
            end
            if (cfg_we)
            begin
                id_limit_reg <= cfg_data;
            end
            if (state_reg == S_MOD)
            begin
                used_reg <= used_next;
                if (mod_we)
                begin
                    full_reg[word_reg] <= &mod_wdata;
                end
            end
            if (state_reg == S_MOD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the request at accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= req.kind;
            rid_reg       <= req.req_id;
            req_bit_reg   <= req_bit;
            word_reg      <= (req.kind == KIND_ALLOC) ? sum_idx : req_word;
            base_reg      <= CMPW'(int'(sum_idx) * WORD_BITS);
            nonfull_reg   <= sum_any;
            range_err_reg <= range_err;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MOD)
        begin
            out_id_reg     <= mod_id;
            out_status_reg <= mod_status;
            out_free_reg   <= mod_free;
        end
    end

    assign req.ready      = req_ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.result_id  = out_id_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.free_count = out_free_reg;

`ifndef SYNTH
    a_accept_to_mod: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_MOD))
        else $error("accepted item did not enter modify step");

    a_mod_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |-> !out_valid_reg)
        else $error("output register busy in modify step");

    a_mod_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |=> out_valid_reg)
        else $error("modify step gave no result item");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("word RAM written while idle");

    a_full_track: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MOD) && mod_we) |=> (full_reg[$past(word_reg)] == &$past(mod_wdata)))
        else $error("full bit does not follow written word");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bmid_pkg::*;

    localparam int NUM_IDS     = 256;
    localparam int IDLE_PCT    = 18;
    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 6;
    localparam int PRINT_MAX   = 40;

    // Kind value that the block must reject
    localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

    // Limit register settings
    localparam logic [COUNT_W-1:0] LIMIT_OFF  = 9'd0;
    localparam logic [COUNT_W-1:0] LIMIT_ONE  = 9'd1;
    localparam logic [COUNT_W-1:0] LIMIT_HUGE = 9'd511;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } alloc_rsp_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_data;

    bmid_req_if req_ch ();
    bmid_rsp_if rsp_ch ();

    bitmap_id_allocator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    // Shadow of the allocator state
    logic [NUM_IDS-1:0] taken_map   = '0;
    logic [COUNT_W-1:0] taken_total = '0;
    logic [COUNT_W-1:0] limit_reg   = LIMIT_RESET;

    alloc_rsp_t outstanding_results[$];

    int errors       = 0;
    bit no_idle      = 1'b0;
    bit hold_pending = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int usable_limit();
        return (limit_reg > NUM_IDS) ? NUM_IDS : int'(limit_reg);
    endfunction

    // Apply one request to the shadow state and return the result it gives
    function automatic alloc_rsp_t apply_request(input logic [KIND_W-1:0] kind,
                                                 input logic [ID_W-1:0] rid);
        alloc_rsp_t r;
        int         lim;
        bit         found;
        lim      = usable_limit();
        found    = 1'b0;
        r.id     = '0;
        r.status = STAT_OK;
        if (kind == KIND_ALLOC)
        begin
            r.status = STAT_NONE_FREE;
            for (int i = 0; i < lim; i++)
            begin
                if (!found && !taken_map[i])
                begin
                    found        = 1'b1;
                    taken_map[i] = 1'b1;
                    taken_total  = taken_total + 1'b1;
                    r.id         = ID_W'(i);
                    r.status     = STAT_OK;
                end
            end
        end
        else if (kind == KIND_ALLOC_ID || kind == KIND_FREE)
        begin
            if (int'(rid) >= lim)
                r.status = STAT_RANGE;
            else if (kind == KIND_ALLOC_ID)
            begin
                if (taken_map[rid])
                    r.status = STAT_TAKEN;
                else
                begin
                    taken_map[rid] = 1'b1;
                    taken_total    = taken_total + 1'b1;
                    r.id           = rid;
                end
            end
            else
            begin
                if (!taken_map[rid])
                    r.status = STAT_NOT_ALLOC;
                else
                begin
                    taken_map[rid] = 1'b0;
                    taken_total    = taken_total - 1'b1;
                    r.id           = rid;
                end
            end
        end
        else
            r.status = STAT_RANGE;
        r.count = (lim > int'(taken_total)) ? COUNT_W'(lim - int'(taken_total)) : '0;
        return r;
    endfunction

    // Track limit writes and accepted requests
    always @(posedge clk)
    begin
        if (cfg_we)
            limit_reg = cfg_data;
        if (req_ch.valid && req_ch.ready)
            outstanding_results.push_back(apply_request(req_ch.kind, req_ch.req_id));
    end

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_MAX)
            $display("%0t tb: %s", $time, msg);
        errors++;
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        alloc_rsp_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (outstanding_results.size() == 0)
                report_mismatch($sformatf("unexpected result id %0d status %0d count %0d",
                                          rsp_ch.result_id, rsp_ch.status,
                                          rsp_ch.free_count));
            else
            begin
                want = outstanding_results.pop_front();
                if (rsp_ch.result_id !== want.id)
                    report_mismatch($sformatf("result_id %0d, want %0d",
                                              rsp_ch.result_id, want.id));
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              rsp_ch.status, want.status));
                if (rsp_ch.free_count !== want.count)
                    report_mismatch($sformatf("free_count %0d, want %0d",
                                              rsp_ch.free_count, want.count));
            end
        end
    end

    // Result side: random stalls, or one long hold-off on request
    initial
    begin
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
                @(posedge clk);
            end
        end
    end

    // End the run when nothing moves for too long
    initial
    begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb: done, errors");
        $finish;
    end

    // Offer one item and hold it until accepted; valid stays high afterward
    task automatic send_req(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] rid);
        if (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.kind   <= kind;
        req_ch.req_id <= rid;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every result has come back
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(input logic [COUNT_W-1:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Find some identifier below the limit that is in use, else a random one
    function automatic logic [ID_W-1:0] pick_taken(input int lim);
        int start;
        int idx;
        start = $urandom_range(NUM_IDS - 1);
        for (int k = 0; k < NUM_IDS; k++)
        begin
            idx = (start + k) % NUM_IDS;
            if (idx < lim && taken_map[idx])
                return ID_W'(idx);
        end
        return ID_W'($urandom);
    endfunction

    // Mostly useful requests, with a few rejects mixed in
    task automatic send_random();
        int                pick;
        int                lim;
        logic [ID_W-1:0]   rid;
        logic [KIND_W-1:0] kind;
        pick = $urandom_range(99);
        lim  = usable_limit();
        rid  = ID_W'($urandom);
        if (pick < 40)
            kind = KIND_ALLOC;
        else if (pick < 65)
        begin
            kind = KIND_ALLOC_ID;
            if (lim > 0 && $urandom_range(99) < 80)
                rid = ID_W'($urandom_range(lim - 1));
        end
        else if (pick < 93)
        begin
            kind = KIND_FREE;
            if ($urandom_range(99) < 85)
                rid = pick_taken(lim);
        end
        else if (pick < 96)
            kind = KIND_BAD;
        else
        begin
            kind = ($urandom_range(1)) ? KIND_FREE : KIND_ALLOC_ID;
            if (lim < NUM_IDS)
                rid = ID_W'($urandom_range(NUM_IDS - 1, lim));
        end
        send_req(kind, rid);
    endtask

    // Field extremes, every kind, and every error status
    task automatic test_directed();
        send_req(KIND_ALLOC, 8'hFF);
        send_req(KIND_ALLOC, 8'h00);
        send_req(KIND_ALLOC_ID, 8'hFF);
        send_req(KIND_ALLOC_ID, 8'hFF);
        send_req(KIND_FREE, 8'h00);
        send_req(KIND_FREE, 8'h00);
        send_req(KIND_ALLOC, 8'h55);
        send_req(KIND_FREE, 8'hFF);
        send_req(KIND_FREE, 8'h80);
        send_req(KIND_BAD, 8'hFF);
        send_req(KIND_BAD, 8'h00);
        send_req(KIND_ALLOC_ID, 8'h00);
        // Limit of one: the bit at 1 stays counted, so the free count saturates
        write_limit(LIMIT_ONE);
        send_req(KIND_ALLOC, 8'hAA);
        send_req(KIND_ALLOC_ID, 8'h01);
        send_req(KIND_FREE, 8'h00);
        send_req(KIND_ALLOC, 8'h00);
        send_req(KIND_FREE, 8'h01);
        // Limit of zero: allocate finds none free, the other kinds are out of range
        write_limit(LIMIT_OFF);
        send_req(KIND_ALLOC, 8'h00);
        send_req(KIND_ALLOC_ID, 8'h00);
        send_req(KIND_FREE, 8'h00);
        // Oversized limit acts as the full table
        write_limit(LIMIT_HUGE);
        send_req(KIND_FREE, 8'h01);
        send_req(KIND_FREE, 8'h00);
        send_req(KIND_ALLOC_ID, 8'h80);
        send_req(KIND_FREE, 8'h80);
    endtask

    // Fill the whole table, overflow it, then free everything in random order
    task automatic test_fill_and_empty();
        logic [ID_W-1:0] held[$];
        logic [ID_W-1:0] tmp;
        int              j;
        write_limit(LIMIT_RESET);
        no_idle = 1'b1;
        repeat (NUM_IDS + 2)
            send_req(KIND_ALLOC, ID_W'($urandom));
        wait_idle();
        for (int i = 0; i < NUM_IDS; i++)
            if (taken_map[i])
                held.push_back(ID_W'(i));
        for (int i = held.size() - 1; i > 0; i--)
        begin
            j       = $urandom_range(i);
            tmp     = held[i];
            held[i] = held[j];
            held[j] = tmp;
        end
        foreach (held[i])
            send_req(KIND_FREE, held[i]);
        no_idle = 1'b0;
    endtask

    // Hold the result side off while requests keep coming
    task automatic test_backpressure();
        wait_idle();
        hold_pending = 1'b1;
        repeat (40)
            send_random();
    endtask

    // Random traffic under a series of limits, extremes included
    task automatic test_random_limits();
        logic [COUNT_W-1:0] limits[8];
        limits = '{LIMIT_RESET, LIMIT_HUGE, 9'd64, 9'd65, 9'd2, 9'd200, 9'd127,
                   COUNT_W'($urandom_range(255, 1))};
        foreach (limits[i])
        begin
            write_limit(limits[i]);
            repeat (140)
                send_random();
        end
    endtask

    // Short bursts, each drained completely before the next
    task automatic test_pause();
        repeat (3)
        begin
            repeat (10)
                send_random();
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_data      <= '0;
        req_ch.valid  <= 1'b0;
        req_ch.kind   <= KIND_ALLOC;
        req_ch.req_id <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_fill_and_empty();
        test_backpressure();
        test_random_limits();
        test_pause();

        wait_idle();
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== bitmap_id_allocator_top.f =====
hdl/bmid_pkg.sv
hdl/bmid_ifs.sv
hdl/bmid_ram.sv
hdl/bmid_ffz.sv
hdl/bitmap_id_allocator_top.sv
bench/tb.sv
